>>> rtl/egdc_pkg.sv
// Shared types and constants for the Elias gamma / delta codec.
// Used by egdc_front, egdc_queue, egdc_back and elias_gamma_delta_codec.
package egdc_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_KIND = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic KIND_GAMMA = 1'b0;
  localparam logic KIND_DELTA = 1'b1;

  typedef struct packed {
    logic [31:0] value;
    logic        code_bit;
  } egdc_in_t;

  typedef struct packed {
    logic [32:0] seg_bits;
    logic [5:0]  seg_len;
    logic        last;
    logic [31:0] decoded;
    logic        decoded_valid;
    logic        fault;
  } egdc_out_t;

  // Work classes handed from the front to the back.
  typedef enum logic [1:0] {
    OP_ENC       = 2'd0,
    OP_ENC_FAULT = 2'd1,
    OP_DEC_VALUE = 2'd2,
    OP_DEC_FAULT = 2'd3
  } egdc_op_t;

  typedef struct packed {
    egdc_op_t    op;
    logic        kind;
    logic [31:0] data;   // x = v+1 for encode, decoded value for decode
  } egdc_entry_t;

  typedef struct packed {
    logic        valid;
    egdc_entry_t entry;
  } egdc_req_t;

endpackage

>>> rtl/egdc_front.sv
// Front end: configuration registers, input accept, encode classification and
// the bit-serial decoder state machine. Depends on egdc_pkg.
module egdc_front import egdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  egdc_in_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 q_ready,
  output egdc_req_t            push
);

  localparam logic [32:0] VMASK     = (33'd1 << VALUE_WIDTH) - 33'd1;
  localparam logic [32:0] MAX_TAIL  = 33'(VALUE_WIDTH);
  localparam logic [5:0]  MAX_ZEROS = 6'd32;

  typedef enum logic [2:0] {
    PH_ZEROS = 3'b001,
    PH_BODY  = 3'b010,
    PH_TAIL  = 3'b100
  } egdc_phase_t;

  logic        direction_r, code_kind_r;
  egdc_phase_t phase_r, phase_nxt;
  logic [5:0]  zero_run_r, zero_run_nxt;
  logic [32:0] accum_r, accum_nxt;
  logic [5:0]  bits_left_r, bits_left_nxt;
  logic        tail_r, tail_nxt;

  logic        in_accept;
  logic        enc_fault;
  logic [31:0] enc_x;
  logic [32:0] shifted, fin_acc, n_m1, v_m1;
  logic [5:0]  bl_dec;
  logic        fin_gamma, fin_value, dec_fault;

  assign in_stall  = !q_ready;
  assign in_accept = in_valid && !in_stall;
  assign enc_fault = {1'b0, in_data.value} >= VMASK;
  assign enc_x     = in_data.value + 32'd1;

  always_comb begin
    phase_nxt     = phase_r;
    zero_run_nxt  = zero_run_r;
    accum_nxt     = accum_r;
    bits_left_nxt = bits_left_r;
    tail_nxt      = tail_r;
    push.valid    = 1'b0;
    push.entry    = '{op: OP_ENC, kind: code_kind_r, data: '0};
    fin_gamma     = 1'b0;
    fin_value     = 1'b0;
    dec_fault     = 1'b0;
    fin_acc       = '0;
    shifted       = {accum_r[31:0], in_data.code_bit};
    bl_dec        = bits_left_r - 6'(bits_left_r != 6'd0);
    n_m1          = '0;
    v_m1          = '0;
    if (direction_r == DIR_ENCODE) begin
      push.valid = in_accept;
      if (enc_fault) begin
        push.entry.op = OP_ENC_FAULT;
      end else begin
        push.entry.data = enc_x;
      end
    end else begin
      case (phase_r)
        PH_ZEROS: begin
          if (!in_data.code_bit) begin
            if (zero_run_r >= MAX_ZEROS) dec_fault = 1'b1;
            else zero_run_nxt = zero_run_r + 6'd1;
          end else begin
            accum_nxt     = 33'd1;
            bits_left_nxt = zero_run_r;
            zero_run_nxt  = '0;
            phase_nxt     = PH_BODY;
            if (zero_run_r == 6'd0) begin
              fin_gamma = 1'b1;
              fin_acc   = 33'd1;
            end
          end
        end
        default: begin
          if (bl_dec != 6'd0) begin
            accum_nxt     = shifted;
            bits_left_nxt = bl_dec;
          end else if (phase_r == PH_BODY) begin
            fin_gamma = 1'b1;
            fin_acc   = shifted;
          end else begin
            fin_value = 1'b1;
            fin_acc   = shifted;
          end
        end
      endcase
      // gamma part complete: either the value itself or a delta length prefix
      if (fin_gamma) begin
        n_m1 = fin_acc - 33'd1;
        if (code_kind_r == KIND_GAMMA || tail_r) begin
          fin_value = 1'b1;
        end else if (fin_acc == 33'd0 || n_m1 > MAX_TAIL) begin
          dec_fault = 1'b1;
        end else if (n_m1 == 33'd0) begin
          fin_value = 1'b1;
          fin_acc   = 33'd1;
        end else begin
          accum_nxt     = 33'd1;
          bits_left_nxt = n_m1[5:0];
          phase_nxt     = PH_TAIL;
          tail_nxt      = 1'b1;
        end
      end
      v_m1 = fin_acc - 33'd1;
      if (fin_value) begin
        if (fin_acc == 33'd0 || v_m1 > VMASK) begin
          dec_fault = 1'b1;
        end else begin
          push.valid      = in_accept;
          push.entry.op   = OP_DEC_VALUE;
          push.entry.data = v_m1[31:0];
        end
      end
      if (dec_fault) begin
        push.valid      = in_accept;
        push.entry.op   = OP_DEC_FAULT;
        push.entry.data = '0;
      end
      if (fin_value || dec_fault) begin
        phase_nxt     = PH_ZEROS;
        zero_run_nxt  = '0;
        accum_nxt     = '0;
        bits_left_nxt = '0;
        tail_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      code_kind_r <= KIND_GAMMA;
      phase_r     <= PH_ZEROS;
      zero_run_r  <= '0;
      accum_r     <= '0;
      bits_left_r <= '0;
      tail_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION: direction_r <= cfg_data;
        CFG_CODE_KIND: code_kind_r <= cfg_data;
        default: ;
      endcase
      // any register write restarts the decoder
      phase_r     <= PH_ZEROS;
      zero_run_r  <= '0;
      accum_r     <= '0;
      bits_left_r <= '0;
      tail_r      <= 1'b0;
    end else if (in_accept && direction_r == DIR_DECODE) begin
      phase_r     <= phase_nxt;
      zero_run_r  <= zero_run_nxt;
      accum_r     <= accum_nxt;
      bits_left_r <= bits_left_nxt;
      tail_r      <= tail_nxt;
    end
  end

  a_tail_phase: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r |-> phase_r == PH_TAIL)
    else $error("delta tail flag set outside tail phase");

  a_zero_run: assert property (@(posedge clk) disable iff (!rst_n)
    zero_run_r <= MAX_ZEROS && (phase_r == PH_ZEROS || zero_run_r == 6'd0))
    else $error("zero run count out of range");

endmodule

>>> rtl/egdc_queue.sv
// Two-entry request queue between the front and the back.
// Depends on egdc_pkg.
module egdc_queue import egdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  egdc_req_t push,
  output logic      ready,
  output egdc_req_t head,
  input  logic      pop
);

  egdc_entry_t mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;

  assign ready      = count_r != 2'd2;
  assign do_push    = push.valid && ready;
  assign head.valid = count_r != 2'd0;
  assign head.entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && count_r == 2'd2) && !(pop && count_r == 2'd0))
    else $error("queue push while full or pop while empty");

endmodule

>>> rtl/egdc_back.sv
// Back end: turns queued requests into result items, one segment per cycle
// for encodes unless stalled, via out_data_r. Depends on egdc_pkg.
module egdc_back import egdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  egdc_req_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output egdc_out_t out_data
);

  typedef enum logic [2:0] {
    ST_ZEROS = 3'b001,
    ST_BODY  = 3'b010,
    ST_TAIL  = 3'b100
  } egdc_step_t;

  function automatic logic [4:0] floor_log2_32(input logic [31:0] x);
    logic [4:0] n;
    n = '0;
    for (int i = 1; i < 32; i++) begin
      if (x[i]) n = 5'(i);
    end
    return n;
  endfunction

  // floor(log2(n+1)) for n up to 31
  function automatic logic [2:0] floor_log2_np1(input logic [4:0] n);
    logic [5:0] y;
    logic [2:0] m;
    y = 6'(n) + 6'd1;
    m = '0;
    for (int i = 1; i < 6; i++) begin
      if (y[i]) m = 3'(i);
    end
    return m;
  endfunction

  logic        job_valid_r;
  egdc_op_t    job_op_r;
  logic        job_kind_r;
  logic [31:0] job_x_r;
  logic [4:0]  job_n_r;
  egdc_step_t  step_r, step_nxt;

  logic        out_valid_r;
  egdc_out_t   out_data_r;
  egdc_out_t   res;
  logic [2:0]  m;
  logic        out_load, done;

  assign m        = floor_log2_np1(job_n_r);
  assign out_load = job_valid_r && (!out_valid_r || !out_stall);
  assign done     = out_load && res.last;
  assign pop      = head.valid && (!job_valid_r || done);

  always_comb begin
    res      = '0;
    step_nxt = step_r;
    case (job_op_r)
      OP_ENC: begin
        case (step_r)
          ST_ZEROS: begin
            res.seg_len = (job_kind_r == KIND_DELTA) ? 6'(m) : 6'(job_n_r);
            step_nxt    = ST_BODY;
          end
          ST_BODY: begin
            if (job_kind_r == KIND_DELTA) begin
              res.seg_bits = 33'(job_n_r) + 33'd1;
              res.seg_len  = 6'(m) + 6'd1;
            end else begin
              res.seg_bits = {1'b0, job_x_r};
              res.seg_len  = 6'(job_n_r) + 6'd1;
            end
            if (job_kind_r == KIND_DELTA && job_n_r != 5'd0) step_nxt = ST_TAIL;
            else res.last = 1'b1;
          end
          ST_TAIL: begin
            res.seg_bits = {1'b0, job_x_r} & ((33'd1 << job_n_r) - 33'd1);
            res.seg_len  = 6'(job_n_r);
            res.last     = 1'b1;
          end
          default: res.last = 1'b1;
        endcase
      end
      OP_DEC_VALUE: begin
        res.decoded       = job_x_r;
        res.decoded_valid = 1'b1;
        res.last          = 1'b1;
      end
      default: begin
        res.fault = 1'b1;
        res.last  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= ST_ZEROS;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        job_valid_r <= 1'b1;
        // a zero run precedes the body exactly when x > 1
        step_r      <= (|head.entry.data[31:1]) ? ST_ZEROS : ST_BODY;
      end else if (done) begin
        job_valid_r <= 1'b0;
      end else if (out_load) begin
        step_r <= step_nxt;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_op_r   <= head.entry.op;
      job_kind_r <= head.entry.kind;
      job_x_r    <= head.entry.data;
      job_n_r    <= floor_log2_32(head.entry.data);
    end
    if (out_load) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_job_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !res.last) |=> job_valid_r)
    else $error("job dropped before its last segment");

  a_decode_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.decoded_valid || out_data_r.fault))
      |-> out_data_r.seg_len == 6'd0 && out_data_r.last)
    else $error("decode or fault result carries segment bits");

endmodule

>>> rtl/elias_gamma_delta_codec.sv
// Elias gamma / delta codec top level: front, request queue and back.
// Depends on egdc_pkg, egdc_front, egdc_queue and egdc_back.
//
// Encoding: one result per segment, so an item gives 1 to 3 results on the
// output (zero run, gamma bits, delta low bits); a fault gives 1. Decoding
// takes one code bit per cycle unless stalled, and gives one result when a
// code completes. The back sequencer, one segment per cycle unless stalled,
// sets the encode rate; a two-entry queue lets input flow as segments drain.
module elias_gamma_delta_codec import egdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  egdc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output egdc_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  egdc_req_t push, head;
  logic      q_ready, pop;

  egdc_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_ready  (q_ready),
    .push     (push)
  );

  egdc_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .ready(q_ready),
    .head (head),
    .pop  (pop)
  );

  egdc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
